@@ src/bh4_pkg.sv @@
package bh4_pkg;

	localparam logic [7:0] RLE_MARK = 8'h90;
	localparam logic [7:0] CHAR_CR = 8'h0d;
	localparam logic [7:0] CHAR_LF = 8'h0a;
	localparam logic [7:0] CHAR_COLON = 8'h3a;
	localparam logic [5:0] HDR_LAST = 6'd47;

	// Header line, line break and opening colon, first character in the top byte.
	localparam logic [8*48-1:0] HDR_TEXT =
		{"(This file must be converted with BinHex 4.0)", CHAR_CR, CHAR_LF, CHAR_COLON};

	localparam logic [8*64-1:0] SYM_MAP =
		"!\"#$%&'()*+,-012345689@ABCDEFGHIJKLMNPQRSTUVXYZ[`abcdefhijklmpqr";

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_DATA = 2'd1,
		OP_END = 2'd2,
		OP_FINISH = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		JOB_HDR,
		JOB_BYTES,
		JOB_FIN
	} job_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HDR,
		ST_BYTES,
		ST_PAD,
		ST_COLON,
		ST_TCR,
		ST_TLF
	} emit_state_t;

	typedef struct packed {
		job_kind_t kind;
		logic [3:0] cnt;
		logic [7:0][7:0] bytes;
	} job_t;

	typedef struct packed {
		logic [2:0] cnt;
		logic [3:0][7:0] bytes;
	} flush_t;

	typedef struct packed {
		logic [7:0] rb;
		logic [7:0] rc;
	} run_t;

	typedef struct packed {
		run_t run;
		flush_t fl;
	} run_step_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] t;
		t = {crc[15:8], 8'h00};
		for (int i = 0; i < 8; i++) begin
			t = t[15] ? ({t[14:0], 1'b0} ^ 16'h1021) : {t[14:0], 1'b0};
		end
		return {crc[7:0], b} ^ t;
	endfunction

	function automatic flush_t flush_run(input run_t r);
		flush_t f;
		f = '0;
		if (r.rb == RLE_MARK) begin
			f.bytes[0] = RLE_MARK;
			f.bytes[1] = 8'h00;
			f.bytes[2] = RLE_MARK;
			if (r.rc < 8'd3) begin
				f.bytes[3] = 8'h00;
				f.cnt = {r.rc[1:0], 1'b0};
			end else begin
				f.bytes[3] = r.rc;
				f.cnt = 3'd4;
			end
		end else if (r.rc < 8'd4) begin
			f.bytes = {4{r.rb}};
			f.cnt = r.rc[2:0];
		end else begin
			f.bytes[0] = r.rb;
			f.bytes[1] = RLE_MARK;
			f.bytes[2] = r.rc;
			f.cnt = 3'd3;
		end
		return f;
	endfunction

	function automatic run_step_t run_stage(input run_t r, input logic [7:0] d);
		run_step_t o;
		o.fl = '0;
		o.run = r;
		if (r.rc != 8'd0 && (r.rc == 8'hff || r.rb != d)) begin
			o.fl = flush_run(r);
			o.run.rc = 8'd0;
		end
		if (o.run.rb == d) begin
			o.run.rc = o.run.rc + 8'd1;
		end else begin
			o.run.rb = d;
			o.run.rc = 8'd1;
		end
		return o;
	endfunction

	function automatic logic [7:0] sym_char(input logic [5:0] s);
		return SYM_MAP[{~s, 3'b000} +: 8];
	endfunction

	function automatic logic [7:0] hdr_char(input logic [5:0] h);
		return HDR_TEXT[{6'(HDR_LAST - h), 3'b000} +: 8];
	endfunction

endpackage

@@ src/bh4_in_if.sv @@
interface bh4_in_if;
	logic valid;
	logic ready;
	logic [1:0] opcode;
	logic [7:0] data_byte;

	modport source (output valid, output opcode, output data_byte, input ready);
	modport sink (input valid, input opcode, input data_byte, output ready);
endinterface

@@ src/bh4_out_if.sv @@
interface bh4_out_if;
	logic valid;
	logic ready;
	logic [7:0] out_char;
	logic last;

	modport source (output valid, output out_char, output last, input ready);
	modport sink (input valid, input out_char, input last, output ready);
endinterface

@@ src/bh4_front.sv @@
module bh4_front (
	input logic clk,
	input logic arst_n,
	bh4_in_if.sink in_ch,
	input logic take,
	output logic job_valid,
	output bh4_pkg::job_t job
);
	import bh4_pkg::*;

	logic pend_q;
	opcode_t op_q;
	logic [7:0] data_q;
	logic [15:0] crc_q;
	run_t run_q;
	logic [15:0] crc_d;
	run_t run_d;

	assign in_ch.ready = !pend_q || take;
	assign job_valid = pend_q;

	always_comb begin
		run_step_t s1;
		run_step_t s2;
		flush_t fl;
		logic [15:0] c;
		logic [3:0] k;
		job = '0;
		job.kind = JOB_BYTES;
		crc_d = crc_q;
		run_d = run_q;
		s1 = '0;
		s2 = '0;
		fl = '0;
		c = '0;
		k = '0;
		case (op_q)
			OP_START: begin
				job.kind = JOB_HDR;
				crc_d = '0;
				run_d = '0;
			end
			OP_DATA: begin
				crc_d = crc_byte(crc_q, data_q);
				s1 = run_stage(run_q, data_q);
				run_d = s1.run;
				job.cnt = {1'b0, s1.fl.cnt};
				job.bytes[3:0] = s1.fl.bytes;
			end
			OP_END: begin
				c = crc_byte(crc_byte(crc_q, 8'h00), 8'h00);
				s1 = run_stage(run_q, c[15:8]);
				s2 = run_stage(s1.run, c[7:0]);
				run_d = s2.run;
				crc_d = '0;
				job.cnt = {1'b0, s1.fl.cnt} + {1'b0, s2.fl.cnt};
				for (int j = 0; j < 8; j++) begin
					k = 4'(j) - {1'b0, s1.fl.cnt};
					if (4'(j) < {1'b0, s1.fl.cnt}) begin
						job.bytes[j] = s1.fl.bytes[j[1:0]];
					end else if (k < 4'd4) begin
						job.bytes[j] = s2.fl.bytes[k[1:0]];
					end
				end
			end
			default: begin
				job.kind = JOB_FIN;
				if (run_q.rc != 8'd0) begin
					fl = flush_run(run_q);
				end
				job.cnt = {1'b0, fl.cnt};
				job.bytes[3:0] = fl.bytes;
				crc_d = '0;
				run_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			crc_q <= '0;
			run_q <= '0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				pend_q <= 1'b1;
			end else if (take) begin
				pend_q <= 1'b0;
			end
			if (take) begin
				crc_q <= crc_d;
				run_q <= run_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			op_q <= opcode_t'(in_ch.opcode);
			data_q <= in_ch.data_byte;
		end
	end
endmodule

@@ src/bh4_emit.sv @@
module bh4_emit #(
	parameter int LINE_LENGTH = 64
) (
	input logic clk,
	input logic arst_n,
	input logic job_valid,
	input bh4_pkg::job_t job,
	output logic take,
	bh4_out_if.source out_ch
);
	import bh4_pkg::*;

	localparam logic [6:0] LINE_LEN = 7'(LINE_LENGTH);

	emit_state_t st_q, st_d;
	job_t job_q;
	logic [2:0] idx_q, idx_d;
	logic [5:0] h_q, h_d;
	logic [1:0] ph_q, ph_d;
	logic [3:0] bits_q, bits_d;
	logic [6:0] lc_q, lc_d;
	logic nl_q, nl_d;
	logic s2v_q, s2v_d;
	logic [5:0] s2_q, s2_d;
	logic out_valid_q;
	logic [7:0] out_char_q;
	logic last_q;

	logic adv;
	logic emit;
	logic [7:0] ch;
	logic lst;
	logic [7:0] cur;
	logic [5:0] sym;
	logic sym_done;
	logic [1:0] sym_ph;
	logic [3:0] sym_bits;
	logic sym_s2v;
	logic [5:0] sym_s2;
	logic last_byte;

	assign adv = !out_valid_q || out_ch.ready;
	assign out_ch.valid = out_valid_q;
	assign out_ch.out_char = out_char_q;
	assign out_ch.last = last_q;

	assign cur = (st_q == ST_PAD) ? 8'h00 : job_q.bytes[idx_q];
	assign last_byte = ({1'b0, idx_q} == (job_q.cnt - 4'd1));

	always_comb begin
		sym = s2_q;
		sym_done = 1'b1;
		sym_ph = ph_q;
		sym_bits = bits_q;
		sym_s2v = 1'b0;
		sym_s2 = s2_q;
		if (!s2v_q) begin
			case (ph_q)
				2'd0: begin
					sym = cur[7:2];
					sym_bits = {2'b00, cur[1:0]};
					sym_ph = 2'd1;
				end
				2'd1: begin
					sym = {bits_q[1:0], cur[7:4]};
					sym_bits = cur[3:0];
					sym_ph = 2'd2;
				end
				default: begin
					sym = {bits_q, cur[7:6]};
					sym_s2 = cur[5:0];
					sym_s2v = 1'b1;
					sym_bits = 4'd0;
					sym_ph = 2'd0;
					sym_done = 1'b0;
				end
			endcase
		end
	end

	always_comb begin
		st_d = st_q;
		idx_d = idx_q;
		h_d = h_q;
		ph_d = ph_q;
		bits_d = bits_q;
		lc_d = lc_q;
		nl_d = nl_q;
		s2v_d = s2v_q;
		s2_d = s2_q;
		emit = 1'b0;
		ch = 8'h00;
		lst = 1'b0;
		take = 1'b0;
		if (adv) begin
			unique case (st_q)
				ST_IDLE: begin
					if (job_valid) begin
						take = 1'b1;
						idx_d = 3'd0;
						case (job.kind)
							JOB_HDR: begin
								st_d = ST_HDR;
								h_d = 6'd0;
								ph_d = 2'd0;
								bits_d = 4'd0;
								s2v_d = 1'b0;
								nl_d = 1'b0;
							end
							JOB_FIN: st_d = (job.cnt != 4'd0) ? ST_BYTES : ST_PAD;
							default: st_d = (job.cnt != 4'd0) ? ST_BYTES : ST_IDLE;
						endcase
					end
				end
				ST_HDR: begin
					emit = 1'b1;
					ch = hdr_char(h_q);
					if (h_q == HDR_LAST) begin
						lst = 1'b1;
						lc_d = 7'd1;
						st_d = ST_IDLE;
					end else begin
						h_d = h_q + 6'd1;
					end
				end
				ST_BYTES, ST_PAD: begin
					if (st_q == ST_PAD && ph_q == 2'd0 && !s2v_q) begin
						st_d = ST_COLON;
					end else if (nl_q) begin
						emit = 1'b1;
						ch = CHAR_LF;
						nl_d = 1'b0;
						lc_d = 7'd0;
					end else if (lc_q >= LINE_LEN) begin
						emit = 1'b1;
						ch = CHAR_CR;
						nl_d = 1'b1;
					end else begin
						emit = 1'b1;
						ch = sym_char(sym);
						lc_d = lc_q + 7'd1;
						ph_d = sym_ph;
						bits_d = sym_bits;
						s2v_d = sym_s2v;
						s2_d = sym_s2;
						if (sym_done) begin
							if (st_q == ST_PAD) begin
								st_d = ST_COLON;
							end else if (last_byte) begin
								if (job_q.kind == JOB_FIN) begin
									st_d = ST_PAD;
								end else begin
									st_d = ST_IDLE;
									lst = 1'b1;
								end
							end else begin
								idx_d = idx_q + 3'd1;
							end
						end
					end
				end
				ST_COLON: begin
					emit = 1'b1;
					if (nl_q) begin
						ch = CHAR_LF;
						nl_d = 1'b0;
						lc_d = 7'd0;
					end else if (lc_q >= LINE_LEN) begin
						ch = CHAR_CR;
						nl_d = 1'b1;
					end else begin
						ch = CHAR_COLON;
						lc_d = lc_q + 7'd1;
						st_d = ST_TCR;
					end
				end
				ST_TCR: begin
					emit = 1'b1;
					ch = CHAR_CR;
					st_d = ST_TLF;
				end
				ST_TLF: begin
					emit = 1'b1;
					ch = CHAR_LF;
					lst = 1'b1;
					ph_d = 2'd0;
					bits_d = 4'd0;
					lc_d = 7'd0;
					s2v_d = 1'b0;
					nl_d = 1'b0;
					st_d = ST_IDLE;
				end
				default: st_d = ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			idx_q <= '0;
			h_q <= '0;
			ph_q <= '0;
			bits_q <= '0;
			lc_q <= '0;
			nl_q <= 1'b0;
			s2v_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			idx_q <= idx_d;
			h_q <= h_d;
			ph_q <= ph_d;
			bits_q <= bits_d;
			lc_q <= lc_d;
			nl_q <= nl_d;
			s2v_q <= s2v_d;
			if (adv) begin
				out_valid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		s2_q <= s2_d;
		if (take) begin
			job_q <= job;
		end
		if (adv && emit) begin
			out_char_q <= ch;
			last_q <= lst;
		end
	end
endmodule

@@ src/binhex4_stream_encoder_unit.sv @@
// Data path: a word is taken into the input register and loaded into the emitter's job register
// once the emitter is idle and its output can advance; its characters then appear on the output register.
// Throughput: one character per cycle from the emitter while the output is ready, plus a load
// step for each command and one more for a finish with no partial group; the next word is
// accepted in the cycle its predecessor is loaded, also for a command that yields no character.
// Reset (arst_n low) clears the CRC, the run stage, the symbol packer and the line count.
module binhex4_stream_encoder_unit #(
	parameter int LINE_LENGTH = 64
) (
	input logic clk,
	input logic arst_n,
	bh4_in_if.sink in_ch,
	bh4_out_if.source out_ch
);
	import bh4_pkg::*;

	logic take;
	logic job_valid;
	job_t job;

	bh4_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.take(take),
		.job_valid(job_valid),
		.job(job)
	);

	bh4_emit #(
		.LINE_LENGTH(LINE_LENGTH)
	) u_emit (
		.clk(clk),
		.arst_n(arst_n),
		.job_valid(job_valid),
		.job(job),
		.take(take),
		.out_ch(out_ch)
	);
endmodule
